FILE: sv/http_request_header_parser_assert.svh
// assertion macros used by the parser top level
`ifndef HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH
`define HTTP_REQUEST_HEADER_PARSER_ASSERT_SVH
`ifndef ASSERT_OFF
`define HRHP_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion failed");
`define HRHP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`else
`define HRHP_ASSERT_NEVER(label, clk, rst_n, cond)
`define HRHP_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/hrhp_pkg.sv
// types, codes and match tables of the request header parser
package hrhp_pkg;

	localparam int PATH_CAP_DEF = 256;
	localparam int TYPE_CAP_DEF = 64;

	localparam logic [16:0] MAX_HEADER_RST = 17'd8192;
	localparam logic [24:0] MAX_BODY_RST = 25'd1048576;

	localparam logic CFG_MAX_HEADER = 1'b0;
	localparam logic CFG_MAX_BODY = 1'b1;

	localparam logic [1:0] KIND_PATH = 2'd0;
	localparam logic [1:0] KIND_TYPE = 2'd1;
	localparam logic [1:0] KIND_VERDICT = 2'd2;

	localparam logic [1:0] ST_COMPLETE = 2'd0;
	localparam logic [1:0] ST_HEADER_BIG = 2'd1;
	localparam logic [1:0] ST_BODY_BIG = 2'd2;

	localparam logic [1:0] METH_UNKNOWN = 2'd0;
	localparam logic [1:0] METH_GET = 2'd1;
	localparam logic [1:0] METH_POST = 2'd2;
	localparam logic [1:0] METH_OPTIONS = 2'd3;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;

	typedef enum logic [3:0] {
		PH_METHOD, PH_SKIPM, PH_PATH, PH_SKIPREQ, PH_LINE, PH_NAME, PH_LENWS,
		PH_LENDIG, PH_TYPEWS, PH_TYPEVAL, PH_SKIPHDR, PH_BODY, PH_DONE
	} phase_t;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       new_message;
	} request_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  out_byte;
		logic        value_start;
		logic [1:0]  method;
		logic [31:0] body_length;
		logic [31:0] total_length;
		logic [1:0]  status;
	} result_t;

	// classified byte handed from front to back
	typedef struct packed {
		logic [7:0] byte_val;
		logic [7:0] lower;
		logic [3:0] digit_val;
		logic       new_message;
		logic       is_digit;
		logic       is_sp;
		logic       is_cr;
		logic       is_lf;
	} class_t;

	function automatic logic [7:0] len_char(input logic [4:0] p);
		logic [7:0] c;
		case (p)
			5'd0: c = "c";  5'd1: c = "o";  5'd2: c = "n";  5'd3: c = "t";
			5'd4: c = "e";  5'd5: c = "n";  5'd6: c = "t";  5'd7: c = "-";
			5'd8: c = "l";  5'd9: c = "e";  5'd10: c = "n"; 5'd11: c = "g";
			5'd12: c = "t"; 5'd13: c = "h"; 5'd14: c = ":";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] typ_char(input logic [4:0] p);
		logic [7:0] c;
		case (p)
			5'd0: c = "c";  5'd1: c = "o";  5'd2: c = "n";  5'd3: c = "t";
			5'd4: c = "e";  5'd5: c = "n";  5'd6: c = "t";  5'd7: c = "-";
			5'd8: c = "t";  5'd9: c = "y";  5'd10: c = "p"; 5'd11: c = "e";
			5'd12: c = ":";
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic [4:0] meth_len(input logic [1:0] m);
		logic [4:0] n;
		case (m)
			METH_GET: n = 5'd4;
			METH_POST: n = 5'd5;
			METH_OPTIONS: n = 5'd8;
			default: n = 5'd0;
		endcase
		return n;
	endfunction

	function automatic logic [7:0] meth_char(input logic [1:0] m, input logic [4:0] p);
		logic [7:0] c;
		c = 8'h00;
		case (m)
			METH_GET: begin
				case (p)
					5'd0: c = "G"; 5'd1: c = "E"; 5'd2: c = "T"; 5'd3: c = " ";
					default: c = 8'h00;
				endcase
			end
			METH_POST: begin
				case (p)
					5'd0: c = "P"; 5'd1: c = "O"; 5'd2: c = "S"; 5'd3: c = "T";
					5'd4: c = " ";
					default: c = 8'h00;
				endcase
			end
			METH_OPTIONS: begin
				case (p)
					5'd0: c = "O"; 5'd1: c = "P"; 5'd2: c = "T"; 5'd3: c = "I";
					5'd4: c = "O"; 5'd5: c = "N"; 5'd6: c = "S"; 5'd7: c = " ";
					default: c = 8'h00;
				endcase
			end
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

FILE: sv/hrhp_fifo.sv
// small register queue used between the parser parts
module hrhp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q, rd_q;
	logic [CW-1:0]    count_q;
	logic             do_push, do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

FILE: sv/hrhp_front.sv
// front end: classifies each request byte for the parser
module hrhp_front (
	input  hrhp_pkg::request_t req,
	output hrhp_pkg::class_t   cls
);
	logic [7:0] b;
	assign b = req.in_byte;

	// character classes
	always_comb begin
		cls.byte_val = b;
		cls.new_message = req.new_message;
		cls.lower = (b >= "A" && b <= "Z") ? (b | 8'h20) : b;
		cls.is_digit = (b >= "0" && b <= "9");
		cls.digit_val = b[3:0];
		cls.is_sp = (b == hrhp_pkg::CH_SP);
		cls.is_cr = (b == hrhp_pkg::CH_CR);
		cls.is_lf = (b == hrhp_pkg::CH_LF);
	end
endmodule

FILE: sv/hrhp_back.sv
// back end: header parser state and result generation
module hrhp_back #(
	parameter int PATH_CAP = hrhp_pkg::PATH_CAP_DEF,
	parameter int TYPE_CAP = hrhp_pkg::TYPE_CAP_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  hrhp_pkg::class_t   cls,
	input  logic [16:0]        max_header,
	input  logic [24:0]        max_body,
	output logic               emit,
	output hrhp_pkg::result_t  res
);
	localparam int PCW = $clog2(PATH_CAP);
	localparam int TCW = $clog2(TYPE_CAP);

	hrhp_pkg::phase_t phase_q, phase_n;
	logic [23:0] last_q, last_n;
	logic [31:0] hcount_q, hcount_n;
	logic [4:0]  pos_q, pos_n;
	logic [1:0]  cand_q, cand_n;
	logic [31:0] acc_q, acc_n;
	logic        neg_q, neg_n;
	logic [1:0]  meth_q, meth_n;
	logic [PCW-1:0] pcount_q, pcount_n;
	logic [TCW-1:0] tcount_q, tcount_n;
	logic        pend_v_q, pend_v_n;
	logic [7:0]  pend_b_q, pend_b_n;
	logic        stop_q, stop_n;
	logic [31:0] body_q, body_n;

	// next state and result for the word at the queue head
	always_comb begin
		logic [7:0]  b;
		logic        term, pemit;
		logic [4:0]  p;
		logic [1:0]  c;
		logic [35:0] v;
		logic [31:0] cl;
		logic [32:0] t;
		logic [31:0] tot;
		b = cls.byte_val;
		term = 1'b0;
		pemit = 1'b0;
		p = '0;
		c = '0;
		v = '0;
		cl = '0;
		t = '0;
		tot = '0;
		phase_n = phase_q; last_n = last_q; hcount_n = hcount_q; pos_n = pos_q;
		cand_n = cand_q; acc_n = acc_q; neg_n = neg_q; meth_n = meth_q;
		pcount_n = pcount_q; tcount_n = tcount_q; pend_v_n = pend_v_q;
		pend_b_n = pend_b_q; stop_n = stop_q; body_n = body_q;
		emit = 1'b0;
		res = '0;
		if (cls.new_message) begin
			phase_n = hrhp_pkg::PH_METHOD; last_n = '0; hcount_n = '0; pos_n = '0;
			cand_n = 2'b11; acc_n = '0; neg_n = 1'b0; meth_n = '0; pcount_n = '0;
			tcount_n = '0; pend_v_n = 1'b0; pend_b_n = '0; stop_n = 1'b0; body_n = '0;
		end
		if (phase_n == hrhp_pkg::PH_DONE) begin
			emit = 1'b0;
		end else if (phase_n == hrhp_pkg::PH_BODY) begin
			body_n = body_n + 32'd1;
			if (body_n >= acc_n) begin
				t = {1'b0, hcount_n} + {1'b0, acc_n};
				emit = 1'b1;
				res.kind = hrhp_pkg::KIND_VERDICT;
				res.method = meth_n;
				res.body_length = acc_n;
				res.total_length = t[32] ? '1 : t[31:0];
				res.status = hrhp_pkg::ST_COMPLETE;
				phase_n = hrhp_pkg::PH_DONE;
			end
		end else begin
			term = (last_n == 24'h0D0A0D) && cls.is_lf;
			last_n = {last_n[15:0], b};
			if (hcount_n != '1) begin
				hcount_n = hcount_n + 32'd1;
			end
			if (!stop_n) begin
				// per-phase parsing
				case (phase_n)
					hrhp_pkg::PH_METHOD: begin
						if (pos_n == '0) begin
							meth_n = (b == "G") ? hrhp_pkg::METH_GET :
								(b == "P") ? hrhp_pkg::METH_POST :
								(b == "O") ? hrhp_pkg::METH_OPTIONS : hrhp_pkg::METH_UNKNOWN;
						end
						if (meth_n != hrhp_pkg::METH_UNKNOWN &&
								pos_n < hrhp_pkg::meth_len(meth_n) &&
								b == hrhp_pkg::meth_char(meth_n, pos_n)) begin
							pos_n = pos_n + 5'd1;
							if (pos_n == hrhp_pkg::meth_len(meth_n)) begin
								phase_n = hrhp_pkg::PH_PATH;
								pos_n = '0;
							end
						end else begin
							meth_n = hrhp_pkg::METH_UNKNOWN;
							pos_n = '0;
							phase_n = cls.is_sp ? hrhp_pkg::PH_PATH : hrhp_pkg::PH_SKIPM;
						end
					end
					hrhp_pkg::PH_SKIPM: begin
						if (cls.is_sp) begin
							phase_n = hrhp_pkg::PH_PATH;
						end
					end
					hrhp_pkg::PH_PATH: begin
						if (cls.is_sp || cls.is_cr) begin
							phase_n = hrhp_pkg::PH_SKIPREQ;
						end else if (cls.is_lf) begin
							phase_n = hrhp_pkg::PH_LINE;
						end else if (pcount_n < PCW'(PATH_CAP - 1)) begin
							pcount_n = pcount_n + 1'b1;
							pemit = 1'b1;
							res.kind = hrhp_pkg::KIND_PATH;
							res.out_byte = b;
						end
					end
					hrhp_pkg::PH_SKIPREQ, hrhp_pkg::PH_SKIPHDR: begin
						if (cls.is_lf) begin
							phase_n = hrhp_pkg::PH_LINE;
						end
					end
					hrhp_pkg::PH_LINE, hrhp_pkg::PH_NAME: begin
						if (phase_n == hrhp_pkg::PH_LINE && (cls.is_cr || cls.is_lf)) begin
							stop_n = 1'b1;
						end else begin
							if (phase_n == hrhp_pkg::PH_LINE) begin
								pos_n = '0;
								cand_n = 2'b11;
							end
							// header name match against both candidates
							p = pos_n;
							c = cand_n;
							if (c[0] && !(p < 5'd15 && cls.lower == hrhp_pkg::len_char(p))) begin
								c[0] = 1'b0;
							end
							if (c[1] && !(p < 5'd13 && cls.lower == hrhp_pkg::typ_char(p))) begin
								c[1] = 1'b0;
							end
							cand_n = c;
							if (c[0] && p == 5'd14) begin
								acc_n = '0;
								neg_n = 1'b0;
								phase_n = hrhp_pkg::PH_LENWS;
							end else if (c[1] && p == 5'd12) begin
								tcount_n = '0;
								pend_v_n = 1'b0;
								pend_b_n = '0;
								phase_n = hrhp_pkg::PH_TYPEWS;
							end else if (c == 2'b00) begin
								phase_n = cls.is_lf ? hrhp_pkg::PH_LINE : hrhp_pkg::PH_SKIPHDR;
							end else begin
								pos_n = p + 5'd1;
								phase_n = hrhp_pkg::PH_NAME;
							end
						end
					end
					hrhp_pkg::PH_LENWS, hrhp_pkg::PH_LENDIG: begin
						v = {acc_n, 3'b000} + {3'b000, acc_n, 1'b0} + {32'd0, cls.digit_val};
						if (phase_n == hrhp_pkg::PH_LENWS && (cls.is_sp || b == hrhp_pkg::CH_TAB)) begin
							phase_n = hrhp_pkg::PH_LENWS;
						end else if (phase_n == hrhp_pkg::PH_LENWS && b == "+") begin
							phase_n = hrhp_pkg::PH_LENDIG;
						end else if (phase_n == hrhp_pkg::PH_LENWS && b == "-") begin
							neg_n = 1'b1;
							phase_n = hrhp_pkg::PH_LENDIG;
						end else if (cls.is_digit) begin
							acc_n = (v[35:32] != '0) ? '1 : v[31:0];
							phase_n = hrhp_pkg::PH_LENDIG;
						end else begin
							phase_n = cls.is_lf ? hrhp_pkg::PH_LINE : hrhp_pkg::PH_SKIPHDR;
						end
					end
					hrhp_pkg::PH_TYPEWS: begin
						if (cls.is_lf) begin
							phase_n = hrhp_pkg::PH_LINE;
						end else if (!cls.is_sp) begin
							pend_v_n = 1'b1;
							pend_b_n = b;
							phase_n = hrhp_pkg::PH_TYPEVAL;
						end
					end
					hrhp_pkg::PH_TYPEVAL: begin
						// flush the held byte unless it is the CR before LF
						if (pend_v_n && tcount_n < TCW'(TYPE_CAP - 1) &&
								!(cls.is_lf && pend_b_n == hrhp_pkg::CH_CR)) begin
							pemit = 1'b1;
							res.kind = hrhp_pkg::KIND_TYPE;
							res.out_byte = pend_b_n;
							res.value_start = (tcount_n == '0);
							tcount_n = tcount_n + 1'b1;
						end
						if (cls.is_lf) begin
							pend_v_n = 1'b0;
							pend_b_n = '0;
							phase_n = hrhp_pkg::PH_LINE;
						end else begin
							pend_v_n = 1'b1;
							pend_b_n = b;
						end
					end
					default: begin
						phase_n = phase_n;
					end
				endcase
			end
			if (term) begin
				// terminator: decide on body
				cl = (neg_n && acc_n != '0) ? '1 : acc_n;
				t = {1'b0, hcount_n} + {1'b0, cl};
				tot = t[32] ? '1 : t[31:0];
				acc_n = cl;
				res = '0;
				res.kind = hrhp_pkg::KIND_VERDICT;
				res.method = meth_n;
				res.total_length = tot;
				if (cl != '0 && (neg_n || cl > {7'd0, max_body})) begin
					emit = 1'b1;
					res.body_length = cl;
					res.status = hrhp_pkg::ST_BODY_BIG;
					phase_n = hrhp_pkg::PH_DONE;
				end else if (cl == '0) begin
					emit = 1'b1;
					res.status = hrhp_pkg::ST_COMPLETE;
					phase_n = hrhp_pkg::PH_DONE;
				end else begin
					emit = 1'b0;
					body_n = '0;
					phase_n = hrhp_pkg::PH_BODY;
				end
			end else if (hcount_n > {15'd0, max_header}) begin
				emit = 1'b1;
				res = '0;
				res.kind = hrhp_pkg::KIND_VERDICT;
				res.method = meth_n;
				res.status = hrhp_pkg::ST_HEADER_BIG;
				phase_n = hrhp_pkg::PH_DONE;
			end else begin
				emit = pemit;
			end
		end
		if (!go) begin
			emit = 1'b0;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hrhp_pkg::PH_METHOD; last_q <= '0; hcount_q <= '0; pos_q <= '0;
			cand_q <= 2'b11; acc_q <= '0; neg_q <= 1'b0; meth_q <= '0; pcount_q <= '0;
			tcount_q <= '0; pend_v_q <= 1'b0; pend_b_q <= '0; stop_q <= 1'b0;
			body_q <= '0;
		end else if (go) begin
			phase_q <= phase_n; last_q <= last_n; hcount_q <= hcount_n; pos_q <= pos_n;
			cand_q <= cand_n; acc_q <= acc_n; neg_q <= neg_n; meth_q <= meth_n;
			pcount_q <= pcount_n; tcount_q <= tcount_n; pend_v_q <= pend_v_n;
			pend_b_q <= pend_b_n; stop_q <= stop_n; body_q <= body_n;
		end
	end
endmodule

FILE: sv/http_request_header_parser.sv
// HTTP request header parser, top level
// Request bytes enter through a queue port: a word is taken when push is high
// and full is low; new_message marks the first byte of a request.
// Results leave through a queue port: the oldest result is shown while empty
// is low and is taken when pop is high. Kinds: path byte, content-type byte,
// and at most one verdict per request (method, lengths, status).
// Configuration: cfg_valid/cfg_ready write cfg_data to register cfg_index
// (0 max header size, 1 max body size); cfg_ready is always high.
// Path: a result caused by a byte taken into the input queue passes through
// the parser into the result queue, and can be popped from there.
// Throughput: one byte per cycle; the parser handles one queued word a cycle
// whenever the result queue has room.
// When pop is held low the result queue fills, the parser stops, then the
// input queue fills and full rises; nothing is lost.
// Reset empties both queues, puts the parser in the method phase and loads
// the default limits of 8192 header bytes and 1048576 body bytes.
module http_request_header_parser #(
	parameter int PATH_CAP = hrhp_pkg::PATH_CAP_DEF,
	parameter int TYPE_CAP = hrhp_pkg::TYPE_CAP_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  hrhp_pkg::request_t request,
	output logic               full,
	input  logic               pop,
	output hrhp_pkg::result_t  result,
	output logic               empty,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [24:0]        cfg_data
);
	`include "http_request_header_parser_assert.svh"

	localparam int CLS_W = $bits(hrhp_pkg::class_t);
	localparam int RES_W = $bits(hrhp_pkg::result_t);

	hrhp_pkg::class_t  cls_in, cls_head;
	hrhp_pkg::result_t res_word;
	logic [CLS_W-1:0]  cls_rd;
	logic [RES_W-1:0]  res_rd;
	logic              cq_empty, rq_full, go, emit;
	logic [16:0]       max_header_q;
	logic [24:0]       max_body_q;

	assign cfg_ready = 1'b1;

	// limit registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_header_q <= hrhp_pkg::MAX_HEADER_RST;
			max_body_q <= hrhp_pkg::MAX_BODY_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == hrhp_pkg::CFG_MAX_HEADER) begin
				max_header_q <= cfg_data[16:0];
			end else begin
				max_body_q <= cfg_data;
			end
		end
	end

	hrhp_front u_front (
		.req (request),
		.cls (cls_in)
	);

	// classified byte queue between front and back
	hrhp_fifo #(.WIDTH(CLS_W), .DEPTH(2)) u_cls_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (cls_in),
		.full   (full),
		.pop    (go),
		.rdata  (cls_rd),
		.empty  (cq_empty)
	);

	assign cls_head = hrhp_pkg::class_t'(cls_rd);
	assign go = !cq_empty && !rq_full;

	hrhp_back #(.PATH_CAP(PATH_CAP), .TYPE_CAP(TYPE_CAP)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.go         (go),
		.cls        (cls_head),
		.max_header (max_header_q),
		.max_body   (max_body_q),
		.emit       (emit),
		.res        (res_word)
	);

	// result queue
	hrhp_fifo #(.WIDTH(RES_W), .DEPTH(2)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (emit),
		.wdata  (res_word),
		.full   (rq_full),
		.pop    (pop),
		.rdata  (res_rd),
		.empty  (empty)
	);

	assign result = hrhp_pkg::result_t'(res_rd);

	`HRHP_ASSERT_NEVER(a_res_overflow, clk, arst_n, emit && rq_full)
	`HRHP_ASSERT_NEVER(a_emit_idle, clk, arst_n, emit && !go)
	`HRHP_ASSERT_NEVER(a_kind_valid, clk, arst_n, !empty && result.kind == 2'd3)
	`HRHP_ASSERT_IMPLIES(a_hdr_err, clk, arst_n,
		!empty && result.status == hrhp_pkg::ST_HEADER_BIG,
		result.body_length == 32'd0 && result.total_length == 32'd0)
endmodule

FILE: tb/tb_http_request_header_parser.sv
// self-checking testbench for the http request header parser
module tb_http_request_header_parser;

	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 8;

	// request parser behaviour plus the queue of results still owed
	class parse_scoreboard;
		hrhp_pkg::result_t owed[$];
		int errors;
		logic [16:0] max_hdr;
		logic [24:0] max_body;
		hrhp_pkg::phase_t ph;
		logic [23:0] tail3;
		logic [31:0] hdr_n, len_acc, body_n;
		int mpos, path_n, type_n;
		logic [1:0] cand, meth;
		bit len_neg, pend_ok, stopped, have_word;
		logic [7:0] pend_b;
		hrhp_pkg::result_t word_out;

		function void restart();
			ph = hrhp_pkg::PH_METHOD; tail3 = '0; hdr_n = '0; mpos = 0; cand = 2'b11;
			len_acc = '0; len_neg = 0; meth = hrhp_pkg::METH_UNKNOWN; path_n = 0;
			type_n = 0; pend_ok = 0; pend_b = '0; stopped = 0; body_n = '0;
		endfunction

		function void power_up();
			max_hdr = hrhp_pkg::MAX_HEADER_RST;
			max_body = hrhp_pkg::MAX_BODY_RST;
			errors = 0;
			restart();
		endfunction

		function string meth_word(logic [1:0] m);
			case (m)
				hrhp_pkg::METH_GET: return "GET ";
				hrhp_pkg::METH_POST: return "POST ";
				hrhp_pkg::METH_OPTIONS: return "OPTIONS ";
				default: return "";
			endcase
		endfunction

		function hrhp_pkg::result_t make(logic [1:0] k, logic [7:0] b, logic s,
				logic [1:0] m, logic [31:0] cl, logic [31:0] tot, logic [1:0] st);
			hrhp_pkg::result_t r;
			r.kind = k; r.out_byte = b; r.value_start = s; r.method = m;
			r.body_length = cl; r.total_length = tot; r.status = st;
			return r;
		endfunction

		function void emit_word(hrhp_pkg::result_t r);
			word_out = r;
			have_word = 1;
		endfunction

		function void flush_type();
			if (pend_ok && type_n < hrhp_pkg::TYPE_CAP_DEF - 1) begin
				emit_word(make(hrhp_pkg::KIND_TYPE, pend_b, type_n == 0, 0, 0, 0, 0));
				type_n++;
			end
			pend_ok = 0;
		endfunction

		function void add_digit(logic [7:0] b);
			logic [63:0] v;
			v = {32'b0, len_acc} * 10 + (b - "0");
			len_acc = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
		endfunction

		function void name_step(logic [7:0] b);
			string ln, tn;
			logic [7:0] lb;
			ln = "content-length:";
			tn = "content-type:";
			lb = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
			if (cand[0] && !(mpos < 15 && lb == ln[mpos])) cand[0] = 0;
			if (cand[1] && !(mpos < 13 && lb == tn[mpos])) cand[1] = 0;
			if (cand[0] && mpos == 14) begin
				len_acc = '0; len_neg = 0; ph = hrhp_pkg::PH_LENWS;
			end else if (cand[1] && mpos == 12) begin
				type_n = 0; pend_ok = 0; ph = hrhp_pkg::PH_TYPEWS;
			end else if (cand == 2'b00) begin
				ph = (b == hrhp_pkg::CH_LF) ? hrhp_pkg::PH_LINE : hrhp_pkg::PH_SKIPHDR;
			end else begin
				mpos++;
				ph = hrhp_pkg::PH_NAME;
			end
		endfunction

		// one header byte through the phase machine
		function void parse(logic [7:0] b);
			string mw;
			bit dig;
			dig = (b >= "0" && b <= "9");
			case (ph)
				hrhp_pkg::PH_METHOD: begin
					if (mpos == 0)
						meth = (b == "G") ? hrhp_pkg::METH_GET :
							(b == "P") ? hrhp_pkg::METH_POST :
							(b == "O") ? hrhp_pkg::METH_OPTIONS : hrhp_pkg::METH_UNKNOWN;
					mw = meth_word(meth);
					if (meth != hrhp_pkg::METH_UNKNOWN && mpos < mw.len() && b == mw[mpos]) begin
						mpos++;
						if (mpos == mw.len()) begin
							ph = hrhp_pkg::PH_PATH; mpos = 0;
						end
					end else begin
						meth = hrhp_pkg::METH_UNKNOWN; mpos = 0;
						ph = (b == hrhp_pkg::CH_SP) ? hrhp_pkg::PH_PATH : hrhp_pkg::PH_SKIPM;
					end
				end
				hrhp_pkg::PH_SKIPM: if (b == hrhp_pkg::CH_SP) ph = hrhp_pkg::PH_PATH;
				hrhp_pkg::PH_PATH: begin
					if (b == hrhp_pkg::CH_SP || b == hrhp_pkg::CH_CR) ph = hrhp_pkg::PH_SKIPREQ;
					else if (b == hrhp_pkg::CH_LF) ph = hrhp_pkg::PH_LINE;
					else if (path_n < hrhp_pkg::PATH_CAP_DEF - 1) begin
						path_n++;
						emit_word(make(hrhp_pkg::KIND_PATH, b, 0, 0, 0, 0, 0));
					end
				end
				hrhp_pkg::PH_SKIPREQ, hrhp_pkg::PH_SKIPHDR:
					if (b == hrhp_pkg::CH_LF) ph = hrhp_pkg::PH_LINE;
				hrhp_pkg::PH_LINE: begin
					if (b == hrhp_pkg::CH_CR || b == hrhp_pkg::CH_LF) stopped = 1;
					else begin
						mpos = 0; cand = 2'b11;
						name_step(b);
					end
				end
				hrhp_pkg::PH_NAME: name_step(b);
				hrhp_pkg::PH_LENWS: begin
					if (b == hrhp_pkg::CH_SP || b == hrhp_pkg::CH_TAB) ;
					else if (b == "+") ph = hrhp_pkg::PH_LENDIG;
					else if (b == "-") begin
						len_neg = 1; ph = hrhp_pkg::PH_LENDIG;
					end else if (dig) begin
						add_digit(b); ph = hrhp_pkg::PH_LENDIG;
					end else
						ph = (b == hrhp_pkg::CH_LF) ? hrhp_pkg::PH_LINE : hrhp_pkg::PH_SKIPHDR;
				end
				hrhp_pkg::PH_LENDIG: begin
					if (dig) add_digit(b);
					else ph = (b == hrhp_pkg::CH_LF) ? hrhp_pkg::PH_LINE : hrhp_pkg::PH_SKIPHDR;
				end
				hrhp_pkg::PH_TYPEWS: begin
					if (b == hrhp_pkg::CH_SP) ;
					else if (b == hrhp_pkg::CH_LF) ph = hrhp_pkg::PH_LINE;
					else begin
						pend_ok = 1; pend_b = b; ph = hrhp_pkg::PH_TYPEVAL;
					end
				end
				hrhp_pkg::PH_TYPEVAL: begin
					if (b == hrhp_pkg::CH_LF) begin
						// a cr right before the lf is not part of the value
						if (!(pend_ok && pend_b == hrhp_pkg::CH_CR)) flush_type();
						pend_ok = 0;
						ph = hrhp_pkg::PH_LINE;
					end else begin
						flush_type();
						pend_ok = 1; pend_b = b;
					end
				end
				default: ;
			endcase
		endfunction

		function logic [31:0] sat_add(logic [31:0] a, logic [31:0] c);
			logic [32:0] t;
			t = a + c;
			return t[32] ? 32'hFFFF_FFFF : t[31:0];
		endfunction

		// accepted input word: advance the model and queue what it produces
		function void note_request(hrhp_pkg::request_t rq);
			logic [7:0] b;
			logic [31:0] cl;
			bit term;
			b = rq.in_byte;
			have_word = 0;
			if (rq.new_message) restart();
			if (ph == hrhp_pkg::PH_DONE) return;
			if (ph == hrhp_pkg::PH_BODY) begin
				body_n++;
				if (body_n >= len_acc) begin
					owed.push_back(make(hrhp_pkg::KIND_VERDICT, 0, 0, meth, len_acc,
						sat_add(hdr_n, len_acc), hrhp_pkg::ST_COMPLETE));
					ph = hrhp_pkg::PH_DONE;
				end
				return;
			end
			term = (tail3 == {hrhp_pkg::CH_CR, hrhp_pkg::CH_LF, hrhp_pkg::CH_CR}) &&
				b == hrhp_pkg::CH_LF;
			tail3 = {tail3[15:0], b};
			if (hdr_n != 32'hFFFF_FFFF) hdr_n++;
			if (!stopped) parse(b);
			if (term) begin
				cl = (len_neg && len_acc != 0) ? 32'hFFFF_FFFF : len_acc;
				len_acc = cl;
				if (cl > 0 && (len_neg || cl > max_body)) begin
					owed.push_back(make(hrhp_pkg::KIND_VERDICT, 0, 0, meth, cl,
						sat_add(hdr_n, cl), hrhp_pkg::ST_BODY_BIG));
					ph = hrhp_pkg::PH_DONE;
				end else if (cl == 0) begin
					owed.push_back(make(hrhp_pkg::KIND_VERDICT, 0, 0, meth, 0, hdr_n,
						hrhp_pkg::ST_COMPLETE));
					ph = hrhp_pkg::PH_DONE;
				end else begin
					body_n = '0;
					ph = hrhp_pkg::PH_BODY;
				end
			end else if (hdr_n > max_hdr) begin
				// the byte due on this step is dropped
				owed.push_back(make(hrhp_pkg::KIND_VERDICT, 0, 0, meth, 0, 0,
					hrhp_pkg::ST_HEADER_BIG));
				ph = hrhp_pkg::PH_DONE;
			end else if (have_word) owed.push_back(word_out);
		endfunction

		function void field(string nm, logic [31:0] e, logic [31:0] a);
			if (e !== a) begin
				$display("%0t mismatch %s: expected %0h actual %0h", $time, nm, e, a);
				errors++;
			end
		endfunction

		function void check_result(hrhp_pkg::result_t r);
			hrhp_pkg::result_t e;
			if (owed.size() == 0) begin
				$display("%0t unexpected result word kind %0d byte %0h", $time, r.kind,
					r.out_byte);
				errors++;
				return;
			end
			e = owed.pop_front();
			field("kind", e.kind, r.kind);
			field("out_byte", e.out_byte, r.out_byte);
			field("value_start", e.value_start, r.value_start);
			field("method", e.method, r.method);
			field("body_length", e.body_length, r.body_length);
			field("total_length", e.total_length, r.total_length);
			field("status", e.status, r.status);
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic push = 0;
	hrhp_pkg::request_t request = '0;
	logic full;
	logic pop = 0;
	hrhp_pkg::result_t result;
	logic empty;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic cfg_index = hrhp_pkg::CFG_MAX_HEADER;
	logic [24:0] cfg_data = '0;

	parse_scoreboard sb;
	bit idle_on = 1;
	int quiet_cycles = 0;
	int sent = 0;

	http_request_header_parser uut (
		.clk(clk), .arst_n(arst_n), .push(push), .request(request), .full(full),
		.pop(pop), .result(result), .empty(empty), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// monitor: accepted words in both directions, plus the watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) sb.note_request(request);
			if (pop && !empty) sb.check_result(result);
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= IDLE_LIMIT) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// result side: pop held low in random bursts
	initial begin
		@(posedge arst_n);
		forever begin
			if (idle_on && $urandom_range(0, 9) == 0) begin
				pop <= 0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			pop <= 1;
			@(posedge clk);
		end
	end

	task automatic send_word(logic [7:0] b, logic nm);
		if (idle_on && $urandom_range(0, 15) == 0) begin
			push <= 0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		push <= 1;
		request.in_byte <= b;
		request.new_message <= nm;
		do @(posedge clk); while (full);
		sent++;
	endtask

	task automatic send_stream(ref logic [7:0] q[$], input logic first_nm);
		foreach (q[i]) send_word(q[i], i == 0 ? first_nm : 1'b0);
	endtask

	// pause the sender until every owed result word has come out
	task automatic drain();
		push <= 0;
		@(posedge clk);
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [24:0] v);
		drain();
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		if (idx == hrhp_pkg::CFG_MAX_HEADER) sb.max_hdr = v[16:0];
		else sb.max_body = v;
	endtask

	function automatic void add_text(ref logic [7:0] q[$], input string s);
		for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
	endfunction

	function automatic void add_mixed_case(ref logic [7:0] q[$], input string s);
		logic [7:0] c;
		for (int i = 0; i < s.len(); i++) begin
			c = s[i];
			if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
			q.push_back(c);
		end
	endfunction

	function automatic void add_eol(ref logic [7:0] q[$]);
		if ($urandom_range(0, 9) == 0) q.push_back(hrhp_pkg::CH_LF);
		else add_text(q, "\r\n");
	endfunction

	// well-formed request with random content, sometimes bent out of shape
	function automatic void build_request(ref logic [7:0] q[$]);
		int n;
		q.delete();
		case ($urandom_range(0, 6))
			0, 1: add_text(q, "GET ");
			2: add_text(q, "POST ");
			3: add_text(q, "OPTIONS ");
			4: add_text(q, "BREW ");
			5: add_text(q, "GEX ");
			default: add_text(q, " ");
		endcase
		n = ($urandom_range(0, 12) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 12);
		repeat (n) q.push_back(8'($urandom_range(33, 126)));
		case ($urandom_range(0, 3))
			0: add_text(q, "\r\n");
			1: q.push_back(hrhp_pkg::CH_LF);
			default: add_text(q, " HTTP/1.1\r\n");
		endcase
		repeat ($urandom_range(0, 4)) begin
			case ($urandom_range(0, 5))
				0, 1: begin
					add_mixed_case(q, "content-length:");
					repeat ($urandom_range(0, 2))
						q.push_back($urandom_range(0, 1) ? hrhp_pkg::CH_SP : hrhp_pkg::CH_TAB);
					case ($urandom_range(0, 5))
						0: q.push_back("+");
						1: q.push_back("-");
						default: ;
					endcase
					case ($urandom_range(0, 5))
						0: add_text(q, "98765432109");
						1: ;
						2: add_text(q, "12x");
						default: add_text(q, $sformatf("%0d", $urandom_range(0, 40)));
					endcase
				end
				2: begin
					add_mixed_case(q, "content-type:");
					repeat ($urandom_range(0, 2)) q.push_back(hrhp_pkg::CH_SP);
					n = ($urandom_range(0, 8) == 0) ? 70 : $urandom_range(0, 8);
					repeat (n) q.push_back(8'($urandom_range(33, 126)));
				end
				3: add_text(q, "Host: x");
				4: add_mixed_case(q, "content-lengthx: 5");
				default: add_text(q, "content");
			endcase
			add_eol(q);
		end
		add_text(q, "\r\n");
		repeat ($urandom_range(0, 45)) q.push_back(8'($urandom_range(0, 255)));
		// a broken one now and then
		if ($urandom_range(0, 9) == 0) q = q[0:$urandom_range(0, q.size() - 1)];
	endfunction

	function automatic void build_noise(ref logic [7:0] q[$]);
		q.delete();
		repeat ($urandom_range(1, 30)) q.push_back(8'($urandom_range(0, 255)));
	endfunction

	initial begin
		logic [7:0] q[$];
		int goal;
		logic [16:0] hdr_set[5];
		logic [24:0] body_set[5];
		hdr_set = '{17'd1, 17'd65536, 17'd60, 17'd8192, 17'd300};
		body_set = '{25'd0, 25'd16777216, 25'd20, 25'd1048576, 25'd5};
		sb = new();
		sb.power_up();
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: short complete requests under the reset limits
		add_text(q, "GET /\r\n\r\n");
		send_stream(q, 1'b1);
		q.delete();
		add_text(q, "OPTIONS *\r\n\r\n");
		send_stream(q, 1'b1);

		// random phases, one pair of limit settings each
		for (int p = 0; p < 5; p++) begin
			write_reg(hrhp_pkg::CFG_MAX_HEADER, 25'(hdr_set[p]));
			write_reg(hrhp_pkg::CFG_MAX_BODY, body_set[p]);
			if (p == 4) idle_on = 0;
			goal = sent + 240;
			while (sent < goal) begin
				if ($urandom_range(0, 7) == 0) begin
					build_noise(q);
					send_stream(q, 1'($urandom_range(0, 1)));
				end else begin
					build_request(q);
					send_stream(q, 1'b1);
				end
			end
		end

		push <= 0;
		@(posedge clk);
		while (sb.owed.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
